>>> design/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with active-low reset disable
`define ASSERT_CLKRST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("two-body integrator assertion failed");

// clocked property, always checked
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("two-body integrator assertion failed");

`endif

>>> design/tbgi_pkg.sv
// Types, constants and the sequencer program of the two-body integrator.
// No dependencies; imported by the unit and its checker.
package tbgi_pkg;

  localparam int FRAC_BITS = 32;

  typedef logic signed [63:0] q_t;

  typedef struct packed {
    logic kind;
    q_t   load_pos1_x;
    q_t   load_pos1_y;
    q_t   load_pos2_x;
    q_t   load_pos2_y;
    q_t   load_vel1_x;
    q_t   load_vel1_y;
    q_t   load_vel2_x;
    q_t   load_vel2_y;
    q_t   load_start_time;
  } in_item_t;

  typedef struct packed {
    q_t out_pos1_x;
    q_t out_pos1_y;
    q_t out_pos2_x;
    q_t out_pos2_y;
    q_t out_vel1_x;
    q_t out_vel1_y;
    q_t out_vel2_x;
    q_t out_vel2_y;
    q_t out_time;
  } out_item_t;

  typedef enum logic [2:0] {
    CFG_METHOD    = 3'd0,
    CFG_TIME_STEP = 3'd1,
    CFG_END_TIME  = 3'd2,
    CFG_GRAV      = 3'd3,
    CFG_MASS_ONE  = 3'd4,
    CFG_MASS_TWO  = 3'd5
  } cfg_e;

  localparam q_t ONE_Q  = q_t'(64'd1 << FRAC_BITS);
  localparam q_t HALF_Q = q_t'(64'd1 << (FRAC_BITS - 1));
  localparam q_t MAX_Q  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t MIN_Q  = 64'sh8000_0000_0000_0000;

  localparam q_t          DT_RESET  = q_t'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam q_t          END_RESET = q_t'(64'd100 << FRAC_BITS);
  localparam logic [62:0] G_RESET   = 63'(64'd1 << FRAC_BITS);
  localparam logic [62:0] M1_RESET  = 63'(64'd1 << FRAC_BITS);
  localparam logic [62:0] M2_RESET  = 63'(64'd2 << FRAC_BITS);
  localparam q_t          VEL0_Q    = q_t'((64'd4 << FRAC_BITS) / 64'd5);
  localparam q_t          VEL2_Q    = -(VEL0_Q / 64'sd2);

  // unit step counts
  localparam int CNT_W      = 8;
  localparam int MUL_DONE   = 6;
  localparam int DIV_STEPS  = 64 + FRAC_BITS;
  localparam int SQRT_STEPS = 64;
  localparam int LOAD_LAST  = 8;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_NEG, OP_MUL, OP_DIV, OP_SQRT,
    OP_CALL, OP_RET, OP_JMPV, OP_END, OP_BOUND, OP_OUTW, OP_OUTGO
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [5:0] a;
    logic [5:0] b;
    logic [4:0] dst;
  } uinst_t;

  // register file slots, and operand codes above it
  localparam logic [5:0] R_P0 = 6'd0,  R_V0 = 6'd4,  R_Q0 = 6'd8,  R_T = 6'd12;
  localparam logic [5:0] R_DX = 6'd13, R_DY = 6'd14, R_R2 = 6'd15, R_D = 6'd16;
  localparam logic [5:0] R_D3 = 6'd17, R_NUM = 6'd18, R_F = 6'd19, R_FX = 6'd20;
  localparam logic [5:0] R_FY = 6'd21, R_A0 = 6'd22, R_RATIO = 6'd26;
  localparam logic [5:0] R_T1 = 6'd27, R_T2 = 6'd28, R_T3 = 6'd29;
  localparam logic [5:0] S_DT = 6'd32, S_G = 6'd33, S_M1 = 6'd34, S_M2 = 6'd35;
  localparam logic [5:0] S_HALF = 6'd36, S_ZERO = 6'd37;

  localparam int RF_DEPTH = 32;
  localparam int RF_AW    = $clog2(RF_DEPTH);

  localparam int PC_W = 7;
  localparam logic [PC_W-1:0] PC_SEED   = 7'd0;
  localparam logic [PC_W-1:0] PC_TICK   = 7'd31;
  localparam logic [PC_W-1:0] PC_VERLET = 7'd66;
  localparam logic [PC_W-1:0] PC_FORCE  = 7'd100;

  function automatic uinst_t mk(input op_e op, input logic [5:0] d,
                                input logic [5:0] a, input logic [5:0] b);
    uinst_t u;
    u.op  = op;
    u.a   = a;
    u.b   = b;
    u.dst = d[4:0];
    return u;
  endfunction

  function automatic q_t default_state(input logic [3:0] idx);
    q_t v;
    case (idx)
      4'd1:    v = ONE_Q;
      4'd3:    v = -HALF_Q;
      4'd4:    v = VEL0_Q;
      4'd6:    v = VEL2_Q;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic uinst_t ucode(input logic [PC_W-1:0] pc);
    int         p;
    int         base;
    int         k;
    logic [5:0] kk;
    uinst_t     u;
    p = int'(pc);
    u = mk(OP_END, 6'd0, 6'd0, 6'd0);
    // load seed of previous positions
    if (p == 0) u = mk(OP_CALL, 6'd0, 6'd0, 6'd0);
    if (p == 1) u = mk(OP_DIV, R_RATIO, S_M1, S_M2);
    if (p == 2) u = mk(OP_MUL, R_T1, R_A0, R_RATIO);
    if (p == 3) u = mk(OP_NEG, R_A0 + 6'd2, R_T1, S_ZERO);
    if (p == 4) u = mk(OP_MUL, R_T1, R_A0 + 6'd1, R_RATIO);
    if (p == 5) u = mk(OP_NEG, R_A0 + 6'd3, R_T1, S_ZERO);
    for (k = 0; k < 4; k++) begin
      kk   = 6'(k);
      base = 6 + 6 * k;
      if (p >= base && p < base + 6) begin
        case (p - base)
          0:       u = mk(OP_MUL, R_T1, R_V0 + kk, S_DT);
          1:       u = mk(OP_SUB, R_T2, R_P0 + kk, R_T1);
          2:       u = mk(OP_MUL, R_T1, R_A0 + kk, S_HALF);
          3:       u = mk(OP_MUL, R_T1, R_T1, S_DT);
          4:       u = mk(OP_MUL, R_T1, R_T1, S_DT);
          default: u = mk(OP_ADD, R_Q0 + kk, R_T2, R_T1);
        endcase
      end
    end
    // tick
    if (p == 31) u = mk(OP_BOUND, 6'd0, R_T, S_ZERO);
    if (p >= 32 && p <= 40)
      u = mk(OP_OUTW, 6'(p - 32), (p == 40) ? R_T : 6'(p - 32), S_ZERO);
    if (p == 41) u = mk(OP_OUTGO, 6'd0, 6'd0, 6'd0);
    if (p == 42) u = mk(OP_CALL, 6'd0, 6'd0, 6'd0);
    if (p == 43) u = mk(OP_DIV, R_T1, R_FX, S_M2);
    if (p == 44) u = mk(OP_NEG, R_A0 + 6'd2, R_T1, S_ZERO);
    if (p == 45) u = mk(OP_DIV, R_T1, R_FY, S_M2);
    if (p == 46) u = mk(OP_NEG, R_A0 + 6'd3, R_T1, S_ZERO);
    if (p == 47) u = mk(OP_JMPV, 6'd0, 6'd0, 6'd0);
    for (k = 0; k < 4; k++) begin
      kk   = 6'(k);
      base = 48 + 4 * k;
      if (p >= base && p < base + 4) begin
        case (p - base)
          0:       u = mk(OP_MUL, R_T1, R_A0 + kk, S_DT);
          1:       u = mk(OP_ADD, R_V0 + kk, R_V0 + kk, R_T1);
          2:       u = mk(OP_MUL, R_T1, R_V0 + kk, S_DT);
          default: u = mk(OP_ADD, R_P0 + kk, R_P0 + kk, R_T1);
        endcase
      end
    end
    if (p == 64) u = mk(OP_ADD, R_T, R_T, S_DT);
    for (k = 0; k < 4; k++) begin
      kk   = 6'(k);
      base = 66 + 8 * k;
      if (p >= base && p < base + 8) begin
        case (p - base)
          0:       u = mk(OP_MUL, R_T1, R_A0 + kk, S_DT);
          1:       u = mk(OP_ADD, R_T2, R_P0 + kk, R_P0 + kk);
          2:       u = mk(OP_SUB, R_T2, R_T2, R_Q0 + kk);
          3:       u = mk(OP_MUL, R_T3, R_T1, S_DT);
          4:       u = mk(OP_ADD, R_T2, R_T2, R_T3);
          5:       u = mk(OP_ADD, R_Q0 + kk, R_P0 + kk, S_ZERO);
          6:       u = mk(OP_ADD, R_P0 + kk, R_T2, S_ZERO);
          default: u = mk(OP_ADD, R_V0 + kk, R_V0 + kk, R_T1);
        endcase
      end
    end
    if (p == 98) u = mk(OP_ADD, R_T, R_T, S_DT);
    // pair force and body one acceleration
    case (p)
      100: u = mk(OP_SUB, R_DX, R_P0, R_P0 + 6'd2);
      101: u = mk(OP_SUB, R_DY, R_P0 + 6'd1, R_P0 + 6'd3);
      102: u = mk(OP_MUL, R_T1, R_DX, R_DX);
      103: u = mk(OP_MUL, R_T2, R_DY, R_DY);
      104: u = mk(OP_ADD, R_R2, R_T1, R_T2);
      105: u = mk(OP_SQRT, R_D, R_R2, S_ZERO);
      106: u = mk(OP_MUL, R_T1, R_D, R_D);
      107: u = mk(OP_MUL, R_D3, R_T1, R_D);
      108: u = mk(OP_MUL, R_T1, S_G, S_M1);
      109: u = mk(OP_MUL, R_T2, R_T1, S_M2);
      110: u = mk(OP_NEG, R_NUM, R_T2, S_ZERO);
      111: u = mk(OP_DIV, R_F, R_NUM, R_D3);
      112: u = mk(OP_MUL, R_FX, R_F, R_DX);
      113: u = mk(OP_MUL, R_FY, R_F, R_DY);
      114: u = mk(OP_DIV, R_A0, R_FX, S_M1);
      115: u = mk(OP_DIV, R_A0 + 6'd1, R_FY, S_M1);
      116: u = mk(OP_RET, 6'd0, 6'd0, 6'd0);
      default: ;
    endcase
    return u;
  endfunction

endpackage

>>> design/two_body_gravity_integrator_unit.sv
// Two-body 2D gravity integrator: microcoded sequencer over one shared unit.
// Work per item is set by the restoring divides (96 steps each; five in a tick item), a
// 64-step square root and split multiplies.
// One item at a time; in_ready_o is low while an item is in work. A tick past the bound
// ends without a result. A result may wait in the output register while the next item runs.
// Reset: async active low; the block then loads the default state and seeds it with
// in_ready_o low; configuration writes are taken throughout.
module two_body_gravity_integrator_unit
  import tbgi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_FETCH, S_EXEC} state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PC_W-1:0]  pc_q, ret_q;
  logic             dflt_q;
  logic             out_valid_q;
  logic             method_q;
  q_t               time_step_q, end_time_q;
  logic [62:0]      grav_q, mass1_q, mass2_q;

  q_t               rf [RF_DEPTH];
  q_t               rda_q, rdb_q;
  in_item_t         in_q;
  q_t               out_buf [9];

  logic [63:0]      x_q, y_q, pp_q;
  logic [127:0]     wide_q;
  logic [67:0]      rem_q;
  logic             neg_q;

  uinst_t           inst;
  q_t               opa, opb;
  logic             wb_en;
  logic [RF_AW-1:0] wb_addr;
  q_t               wb_data;
  logic             ex_done;
  q_t               ex_res;
  logic             in_bound;

  logic [1:0]       pp_i, ac_i;
  logic [31:0]      x_h, y_h;
  logic [127:0]     pp_sh;
  logic [63:0]      div_r1;
  logic             div_take;
  logic [67:0]      sq_r1, sq_trial;
  logic             sq_take;

  function automatic q_t s_add(input q_t a, input q_t b);
    q_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? MIN_Q : MAX_Q;
    return s;
  endfunction

  function automatic q_t s_sub(input q_t a, input q_t b);
    q_t s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) s = a[63] ? MIN_Q : MAX_Q;
    return s;
  endfunction

  function automatic q_t s_neg(input q_t a);
    return (a == MIN_Q) ? MAX_Q : -a;
  endfunction

  function automatic logic [63:0] mag(input q_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic q_t from_mag(input logic neg, input logic [127:0] m);
    q_t r;
    if (neg) begin
      if (|m[127:64] || m[63:0] > 64'h8000_0000_0000_0000) r = MIN_Q;
      else r = q_t'(64'd0 - m[63:0]);
    end else begin
      if (|m[127:63]) r = MAX_Q;
      else r = q_t'(m[63:0]);
    end
    return r;
  endfunction

  function automatic q_t src_val(input logic [5:0] s, input q_t rd, input q_t dt,
                                 input logic [62:0] g, input logic [62:0] m1,
                                 input logic [62:0] m2);
    q_t v;
    if (!s[5]) begin
      v = rd;
    end else begin
      case (s)
        S_DT:    v = dt;
        S_G:     v = q_t'({1'b0, g});
        S_M1:    v = q_t'({1'b0, m1});
        S_M2:    v = q_t'({1'b0, m2});
        S_HALF:  v = HALF_Q;
        default: v = '0;
      endcase
    end
    return v;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = '{out_buf[0], out_buf[1], out_buf[2], out_buf[3], out_buf[4],
                         out_buf[5], out_buf[6], out_buf[7], out_buf[8]};

  always_comb begin
    inst = ucode(pc_q);
    opa  = src_val(inst.a, rda_q, time_step_q, grav_q, mass1_q, mass2_q);
    opb  = src_val(inst.b, rdb_q, time_step_q, grav_q, mass1_q, mass2_q);

    // split multiply
    pp_i  = 2'(cnt_q - CNT_W'(1));
    ac_i  = 2'(cnt_q - CNT_W'(2));
    x_h   = pp_i[0] ? x_q[63:32] : x_q[31:0];
    y_h   = pp_i[1] ? y_q[63:32] : y_q[31:0];
    case (ac_i)
      2'd0:    pp_sh = {64'd0, pp_q};
      2'd3:    pp_sh = {pp_q, 64'd0};
      default: pp_sh = {32'd0, pp_q, 32'd0};
    endcase

    // restoring divide step
    div_r1   = {rem_q[62:0], x_q[63]};
    div_take = rem_q[63] || (div_r1 >= y_q);

    // digit-by-digit square root step
    sq_r1    = {rem_q[65:0], wide_q[127:126]};
    sq_trial = {2'b00, x_q, 2'b01};
    sq_take  = (sq_r1 >= sq_trial);

    in_bound = (!time_step_q[63] && |time_step_q) ? (opa <= end_time_q)
                                                   : (opa >= end_time_q);

    ex_done = 1'b0;
    ex_res  = '0;
    case (inst.op)
      OP_ADD: begin
        ex_done = 1'b1;
        ex_res  = s_add(opa, opb);
      end
      OP_SUB: begin
        ex_done = 1'b1;
        ex_res  = s_sub(opa, opb);
      end
      OP_NEG: begin
        ex_done = 1'b1;
        ex_res  = s_neg(opa);
      end
      OP_MUL: begin
        ex_done = (cnt_q == CNT_W'(MUL_DONE));
        ex_res  = from_mag(neg_q, wide_q >> FRAC_BITS);
      end
      OP_DIV: begin
        if (cnt_q == '0) begin
          ex_done = (opb == '0);
          ex_res  = opa[63] ? MIN_Q : ((opa == '0) ? q_t'(0) : MAX_Q);
        end else begin
          ex_done = (cnt_q == CNT_W'(DIV_STEPS + 1));
          ex_res  = from_mag(neg_q, wide_q);
        end
      end
      OP_SQRT: begin
        if (cnt_q == '0) begin
          ex_done = (opa[63] || opa == '0);
          ex_res  = '0;
        end else begin
          ex_done = (cnt_q == CNT_W'(SQRT_STEPS + 1));
          ex_res  = q_t'(x_q);
        end
      end
      default: ;
    endcase

    wb_en   = 1'b0;
    wb_addr = inst.dst;
    wb_data = ex_res;
    if (state_q == S_LOAD) begin
      wb_en   = 1'b1;
      wb_addr = (cnt_q == CNT_W'(LOAD_LAST)) ? R_T[RF_AW-1:0] : cnt_q[RF_AW-1:0];
      if (dflt_q) begin
        wb_data = default_state(cnt_q[3:0]);
      end else begin
        case (cnt_q[3:0])
          4'd0:    wb_data = in_q.load_pos1_x;
          4'd1:    wb_data = in_q.load_pos1_y;
          4'd2:    wb_data = in_q.load_pos2_x;
          4'd3:    wb_data = in_q.load_pos2_y;
          4'd4:    wb_data = in_q.load_vel1_x;
          4'd5:    wb_data = in_q.load_vel1_y;
          4'd6:    wb_data = in_q.load_vel2_x;
          4'd7:    wb_data = in_q.load_vel2_y;
          default: wb_data = in_q.load_start_time;
        endcase
      end
    end else if (state_q == S_EXEC) begin
      wb_en = ex_done;
    end
  end

  always_ff @(posedge clk_i) begin
    rda_q <= rf[inst.a[RF_AW-1:0]];
    rdb_q <= rf[inst.b[RF_AW-1:0]];
    if (wb_en) rf[wb_addr] <= wb_data;
    if (in_valid_i && in_ready_o) in_q <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      pc_q        <= PC_SEED;
      ret_q       <= PC_SEED;
      dflt_q      <= 1'b1;
      out_valid_q <= 1'b0;
      method_q    <= 1'b0;
      time_step_q <= DT_RESET;
      end_time_q  <= END_RESET;
      grav_q      <= G_RESET;
      mass1_q     <= M1_RESET;
      mass2_q     <= M2_RESET;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      if (cfg_valid_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_METHOD:    method_q    <= cfg_data_i[0];
          CFG_TIME_STEP: time_step_q <= q_t'(cfg_data_i);
          CFG_END_TIME:  end_time_q  <= q_t'(cfg_data_i);
          CFG_GRAV:      grav_q      <= cfg_data_i[62:0];
          CFG_MASS_ONE:  mass1_q     <= cfg_data_i[62:0];
          CFG_MASS_TWO:  mass2_q     <= cfg_data_i[62:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cnt_q <= '0;
            if (in_item_i.kind) begin
              pc_q    <= PC_TICK;
              state_q <= S_FETCH;
            end else begin
              dflt_q  <= 1'b0;
              state_q <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          if (cnt_q == CNT_W'(LOAD_LAST)) begin
            pc_q    <= PC_SEED;
            state_q <= S_FETCH;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_FETCH: begin
          cnt_q   <= '0;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          cnt_q <= cnt_q + CNT_W'(1);
          case (inst.op)
            OP_MUL: begin
              if (cnt_q == '0) begin
                x_q    <= mag(opa);
                y_q    <= mag(opb);
                neg_q  <= opa[63] ^ opb[63];
                wide_q <= '0;
              end
              if (cnt_q >= CNT_W'(1) && cnt_q <= CNT_W'(4))
                pp_q <= {32'd0, x_h} * {32'd0, y_h};
              if (cnt_q >= CNT_W'(2) && cnt_q <= CNT_W'(5))
                wide_q <= wide_q + pp_sh;
            end
            OP_DIV: begin
              if (cnt_q == '0) begin
                x_q    <= mag(opa);
                y_q    <= mag(opb);
                neg_q  <= opa[63] ^ opb[63];
                rem_q  <= '0;
                wide_q <= '0;
              end else if (cnt_q <= CNT_W'(DIV_STEPS)) begin
                x_q    <= {x_q[62:0], 1'b0};
                rem_q  <= {4'd0, div_take ? div_r1 - y_q : div_r1};
                wide_q <= {wide_q[126:0], div_take};
              end
            end
            OP_SQRT: begin
              if (cnt_q == '0) begin
                wide_q <= {64'd0, opa} << FRAC_BITS;
                rem_q  <= '0;
                x_q    <= '0;
              end else if (cnt_q <= CNT_W'(SQRT_STEPS)) begin
                wide_q <= {wide_q[125:0], 2'b00};
                rem_q  <= sq_take ? sq_r1 - sq_trial : sq_r1;
                x_q    <= {x_q[62:0], sq_take};
              end
            end
            OP_BOUND: begin
              if (in_bound) begin
                pc_q    <= pc_q + PC_W'(1);
                state_q <= S_FETCH;
              end else begin
                state_q <= S_IDLE;
              end
            end
            OP_OUTW: begin
              if (!out_valid_q) begin
                out_buf[inst.dst[3:0]] <= opa;
                pc_q    <= pc_q + PC_W'(1);
                state_q <= S_FETCH;
              end
            end
            OP_OUTGO: begin
              out_valid_q <= 1'b1;
              pc_q        <= pc_q + PC_W'(1);
              state_q     <= S_FETCH;
            end
            OP_CALL: begin
              ret_q   <= pc_q + PC_W'(1);
              pc_q    <= PC_FORCE;
              state_q <= S_FETCH;
            end
            OP_RET: begin
              pc_q    <= ret_q;
              state_q <= S_FETCH;
            end
            OP_JMPV: begin
              pc_q    <= method_q ? PC_VERLET : pc_q + PC_W'(1);
              state_q <= S_FETCH;
            end
            OP_END: state_q <= S_IDLE;
            default: ;
          endcase
          if (wb_en) begin
            pc_q    <= pc_q + PC_W'(1);
            state_q <= S_FETCH;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/tbgi_checker.sv
// Port-level checker for the two-body integrator, bound to the top level.
// Depends on tbgi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tbgi_checker
  import tbgi_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input in_item_t   in_item_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input out_item_t  out_item_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [2:0] cfg_index_i,
  input logic [63:0] cfg_data_i
);

  // a stalled result holds
  `ASSERT_CLKRST(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))

  // in_ready_o drops once an item is accepted
  `ASSERT_CLKRST(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)

  // a result is only raised while an item is in work
  `ASSERT_CLKRST(a_result_while_busy, clk_i, rst_ni, $rose(out_valid_o) |-> !in_ready_o)

  // configuration is never back-pressured
  `ASSERT_CLK(a_cfg_ready, clk_i, rst_ni |-> cfg_ready_o)

endmodule

bind two_body_gravity_integrator_unit tbgi_checker u_tbgi_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for two_body_gravity_integrator_unit.
// Drives load and tick items through a directed table, then random phases under a
// range of register settings. Every result is checked against a fixed-point predictor or a table snapshot.
module tb_top
  import tbgi_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit          KIND_LOAD  = 1'b0;
  localparam bit          KIND_TICK  = 1'b1;
  localparam int          SETTLE_CYC = 1000;
  localparam longint      CYCLE_CAP  = 6000000;
  localparam logic [63:0] MASK63     = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t snap;
  } row_t;

  typedef struct {
    bit          verlet;
    logic [63:0] dt;
    logic [63:0] t_end;
    logic [63:0] g;
    logic [63:0] m1;
    logic [63:0] m2;
  } setting_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_e      cfg_index = CFG_METHOD;
  logic [63:0] cfg_data = '0;

  two_body_gravity_integrator_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  bit        use_verlet;
  q_t        dt_q, t_end_q, g_q, m1_q, m2_q;
  q_t        pos_q[4], vel_q[4], trail_q[4];
  q_t        now_q;
  out_item_t snapshots[$];
  row_t      dir_rows[$];
  setting_t  plan[$];
  int        mismatches = 0;
  longint    cycles = 0;

  function automatic void queue_result(out_item_t o);
    snapshots.insert(snapshots.size(), o);
  endfunction

  function automatic void add_row(row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_setting(setting_t s);
    plan.insert(plan.size(), s);
  endfunction

  function automatic q_t sat_add(q_t a, q_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(MAX_Q)) return MAX_Q;
    if (s < 65'(MIN_Q)) return MIN_Q;
    return s[63:0];
  endfunction

  function automatic q_t sat_sub(q_t a, q_t b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(MAX_Q)) return MAX_Q;
    if (s < 65'(MIN_Q)) return MIN_Q;
    return s[63:0];
  endfunction

  function automatic q_t sat_neg(q_t a);
    return (a == MIN_Q) ? MAX_Q : -a;
  endfunction

  function automatic logic [63:0] abs_u(q_t a);
    return (a < 0) ? 64'(-a) : 64'(a);
  endfunction

  function automatic q_t signed_fit(bit neg, logic [127:0] m);
    if (neg) begin
      if (m > 128'h8000_0000_0000_0000) return MIN_Q;
      return q_t'(-m[63:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF_FFFF) return MAX_Q;
    return q_t'(m[63:0]);
  endfunction

  function automatic q_t fx_mul(q_t a, q_t b);
    logic [127:0] p;
    p = {64'd0, abs_u(a)} * {64'd0, abs_u(b)};
    return signed_fit((a < 0) != (b < 0), p >> FRAC_BITS);
  endfunction

  function automatic q_t fx_div(q_t a, q_t b);
    logic [127:0] n;
    if (b == 0) return (a > 0) ? MAX_Q : ((a < 0) ? MIN_Q : q_t'(0));
    n = {64'd0, abs_u(a)} << FRAC_BITS;
    return signed_fit((a < 0) != (b < 0), n / {64'd0, abs_u(b)});
  endfunction

  function automatic q_t fx_sqrt(q_t r);
    logic [127:0] n;
    logic [63:0]  root, trial;
    if (r <= 0) return 0;
    n = {64'd0, r} << FRAC_BITS;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if ({64'd0, trial} * {64'd0, trial} <= n) root = trial;
    end
    return q_t'(root);
  endfunction

  function automatic void gravity(output q_t fx, output q_t fy);
    q_t dx, dy, d, d3, num, f;
    dx = sat_sub(pos_q[0], pos_q[2]);
    dy = sat_sub(pos_q[1], pos_q[3]);
    d = fx_sqrt(sat_add(fx_mul(dx, dx), fx_mul(dy, dy)));
    d3 = fx_mul(fx_mul(d, d), d);
    num = sat_neg(fx_mul(fx_mul(g_q, m1_q), m2_q));
    f = fx_div(num, d3);
    fx = fx_mul(f, dx);
    fy = fx_mul(f, dy);
  endfunction

  function automatic void reseed_trail();
    q_t fx, fy, ratio, base, corr;
    q_t acc[4];
    gravity(fx, fy);
    acc[0] = fx_div(fx, m1_q);
    acc[1] = fx_div(fy, m1_q);
    ratio = fx_div(m1_q, m2_q);
    acc[2] = sat_neg(fx_mul(acc[0], ratio));
    acc[3] = sat_neg(fx_mul(acc[1], ratio));
    for (int k = 0; k < 4; k++) begin
      base = sat_sub(pos_q[k], fx_mul(vel_q[k], dt_q));
      corr = fx_mul(fx_mul(fx_mul(acc[k], HALF_Q), dt_q), dt_q);
      trail_q[k] = sat_add(base, corr);
    end
  endfunction

  function automatic out_item_t snapshot();
    out_item_t o;
    o.out_pos1_x = pos_q[0];
    o.out_pos1_y = pos_q[1];
    o.out_pos2_x = pos_q[2];
    o.out_pos2_y = pos_q[3];
    o.out_vel1_x = vel_q[0];
    o.out_vel1_y = vel_q[1];
    o.out_vel2_x = vel_q[2];
    o.out_vel2_y = vel_q[3];
    o.out_time   = now_q;
    return o;
  endfunction

  function automatic void reset_bodies();
    use_verlet = 1'b0;
    dt_q = DT_RESET;
    t_end_q = END_RESET;
    g_q = q_t'({1'b0, G_RESET});
    m1_q = q_t'({1'b0, M1_RESET});
    m2_q = q_t'({1'b0, M2_RESET});
    for (int k = 0; k < 4; k++) begin
      pos_q[k] = default_state(4'(k));
      vel_q[k] = default_state(4'(k + 4));
    end
    now_q = 0;
    reseed_trail();
  endfunction

  function automatic void apply_setting(cfg_e idx, logic [63:0] v);
    case (idx)
      CFG_METHOD:    use_verlet = v[0];
      CFG_TIME_STEP: dt_q = q_t'(v);
      CFG_END_TIME:  t_end_q = q_t'(v);
      CFG_GRAV:      g_q = q_t'(v & MASK63);
      CFG_MASS_ONE:  m1_q = q_t'(v & MASK63);
      CFG_MASS_TWO:  m2_q = q_t'(v & MASK63);
      default: ;
    endcase
  endfunction

  // one accepted item; returns 1 with the snapshot when a result is due
  function automatic bit integrate(in_item_t it, output out_item_t snap);
    q_t  fx, fy, dv, nxt;
    q_t  acc[4];
    bit  in_bound;
    snap = '0;
    if (it.kind == KIND_LOAD) begin
      pos_q = '{it.load_pos1_x, it.load_pos1_y, it.load_pos2_x, it.load_pos2_y};
      vel_q = '{it.load_vel1_x, it.load_vel1_y, it.load_vel2_x, it.load_vel2_y};
      now_q = it.load_start_time;
      reseed_trail();
      return 1'b0;
    end
    in_bound = (dt_q > 0) ? (now_q <= t_end_q) : (now_q >= t_end_q);
    if (!in_bound) return 1'b0;
    snap = snapshot();
    gravity(fx, fy);
    acc[0] = fx_div(fx, m1_q);
    acc[1] = fx_div(fy, m1_q);
    acc[2] = sat_neg(fx_div(fx, m2_q));
    acc[3] = sat_neg(fx_div(fy, m2_q));
    for (int k = 0; k < 4; k++) begin
      dv = fx_mul(acc[k], dt_q);
      if (!use_verlet) begin
        vel_q[k] = sat_add(vel_q[k], dv);
        pos_q[k] = sat_add(pos_q[k], fx_mul(vel_q[k], dt_q));
      end else begin
        nxt = sat_sub(sat_add(pos_q[k], pos_q[k]), trail_q[k]);
        nxt = sat_add(nxt, fx_mul(dv, dt_q));
        trail_q[k] = pos_q[k];
        pos_q[k] = nxt;
        vel_q[k] = sat_add(vel_q[k], dv);
      end
    end
    now_q = sat_add(now_q, dt_q);
    return 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    string     names[9];
    if (rst_n && out_valid && out_ready) begin
      names = '{"pos1_x", "pos1_y", "pos2_x", "pos2_y", "vel1_x", "vel1_y",
                "vel2_x", "vel2_y", "time"};
      if (snapshots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item at cycle %0d", cycles);
      end else begin
        want = snapshots.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (want[575 - 64*i -: 64] !== out_item[575 - 64*i -: 64]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%s mismatch: expected %h got %h", names[i],
                       want[575 - 64*i -: 64], out_item[575 - 64*i -: 64]);
          end
        end
      end
    end
  end

  // receiver stall pattern, in four modes taken in turn
  always @(posedge clk) begin
    case (cycles[9:8])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= (cycles[2:0] != 3'd0);
      default: out_ready <= ($urandom_range(0, 9) > 6);
    endcase
  end

  initial begin
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("[two_body_gravity_integrator_unit] ERROR");
    $finish;
  end

  task automatic send(in_item_t it, bit typed = 1'b0, out_item_t typed_snap = '0);
    out_item_t snap;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    if (integrate(it, snap)) queue_result(typed ? typed_snap : snap);
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (snapshots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(cfg_e idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_setting(idx, v);
  endtask

  task automatic apply_plan(setting_t s);
    write_reg(CFG_METHOD, {63'd0, s.verlet});
    write_reg(CFG_TIME_STEP, s.dt);
    write_reg(CFG_END_TIME, s.t_end);
    write_reg(CFG_GRAV, s.g);
    write_reg(CFG_MASS_ONE, s.m1);
    write_reg(CFG_MASS_TWO, s.m2);
    cfg_valid <= 1'b0;
  endtask

  function automatic q_t rand_q(int wide_mix);
    case ($urandom_range(0, 9))
      0:       return q_t'({$urandom, $urandom});
      1:       return (wide_mix != 0) ? MAX_Q : MIN_Q;
      2:       return q_t'({{29{$urandom_range(0, 1) == 1}}, 35'($urandom) ^ 35'({$urandom, 3'b0})});
      default: return q_t'({{30{$urandom_range(0, 1) == 1}}, 34'({$urandom, $urandom}) & 34'h3_FFFF_FFFF});
    endcase
  endfunction

  function automatic in_item_t load_of(q_t p[4], q_t v[4], q_t t);
    in_item_t it;
    it = '0;
    it.kind = KIND_LOAD;
    {it.load_pos1_x, it.load_pos1_y, it.load_pos2_x, it.load_pos2_y} = {p[0], p[1], p[2], p[3]};
    {it.load_vel1_x, it.load_vel1_y, it.load_vel2_x, it.load_vel2_y} = {v[0], v[1], v[2], v[3]};
    it.load_start_time = t;
    return it;
  endfunction

  function automatic out_item_t snap_of(q_t p[4], q_t v[4], q_t t);
    return {p[0], p[1], p[2], p[3], v[0], v[1], v[2], v[3], t};
  endfunction

  function automatic in_item_t tick_of(int ones);
    in_item_t it;
    it = (ones != 0) ? '1 : '0;
    it.kind = KIND_TICK;
    return it;
  endfunction

  function automatic in_item_t random_noise();
    in_item_t it;
    for (int i = 0; i < 9; i++) it[575 - 64*i -: 64] = {$urandom, $urandom};
    it.kind = 1'($urandom_range(0, 1));
    return it;
  endfunction

  initial begin
    setting_t s;
    q_t       p[4], v[4], t0;
    q_t       dflt_p[4], dflt_v[4];
    q_t       zq[4];
    int       burst_left;
    int       budget;
    int       n_ticks;

    zq = '{0, 0, 0, 0};
    dflt_p = '{0, ONE_Q, 0, -HALF_Q};
    dflt_v = '{VEL0_Q, 0, VEL2_Q, 0};
    p = '{MAX_Q, MIN_Q, MIN_Q, MAX_Q};
    v = '{MIN_Q, MAX_Q, 0, -1};

    add_row('{tick_of(0), 1'b1, snap_of(dflt_p, dflt_v, 0)});
    add_row('{tick_of(1), 1'b0, '0});
    add_row('{tick_of(0), 1'b0, '0});
    // coincident bodies
    add_row('{load_of(zq, zq, 0), 1'b0, '0});
    add_row('{tick_of(0), 1'b1, snap_of(zq, zq, 0)});
    add_row('{tick_of(0), 1'b0, '0});
    // field extremes
    add_row('{load_of(p, v, 0), 1'b0, '0});
    add_row('{tick_of(0), 1'b1, snap_of(p, v, 0)});
    add_row('{tick_of(0), 1'b0, '0});
    add_row('{tick_of(0), 1'b0, '0});
    // start exactly on the bound, then past it
    add_row('{load_of(dflt_p, dflt_v, END_RESET), 1'b0, '0});
    add_row('{tick_of(0), 1'b1, snap_of(dflt_p, dflt_v, END_RESET)});
    add_row('{tick_of(1), 1'b0, '0});
    add_row('{load_of(v, p, MAX_Q), 1'b0, '0});
    add_row('{tick_of(0), 1'b0, '0});
    add_row('{load_of(v, p, MIN_Q), 1'b0, '0});
    add_row('{tick_of(0), 1'b1, snap_of(v, p, MIN_Q)});
    add_row('{tick_of(0), 1'b0, '0});
    add_row('{load_of(dflt_p, dflt_v, 0), 1'b0, '0});
    add_row('{tick_of(0), 1'b0, '0});

    add_setting('{1'b1, 64'(DT_RESET), 64'(END_RESET), 64'(G_RESET), 64'(M1_RESET),
                  64'(M2_RESET)});
    add_setting('{1'b0, 64'(-DT_RESET), 64'(-END_RESET), 64'(ONE_Q), 64'(ONE_Q),
                  64'(ONE_Q)});
    add_setting('{1'b1, 64'd0, 64'(MIN_Q), 64'(ONE_Q) * 3, 64'(HALF_Q), 64'(ONE_Q)});
    add_setting('{1'b0, 64'(MAX_Q), 64'(MAX_Q), 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1});
    add_setting('{1'b1, 64'(MIN_Q), 64'(MIN_Q), 64'h8000_0001_0000_0000, 64'd0, 64'd0});
    add_setting('{1'b0, 64'(DT_RESET) * 7, 64'(ONE_Q) * 5, 64'(MASK63), 64'(ONE_Q) * 2,
                  64'(MASK63)});
    for (int i = 0; i < 5; i++) begin
      s.verlet = 1'($urandom_range(0, 1));
      s.dt = {{33{$urandom_range(0, 3) == 0}}, 31'($urandom)};
      s.t_end = {{24{s.dt[63]}}, 40'({$urandom, $urandom})};
      s.g = {$urandom_range(0, 1) == 1, 27'd0, 36'({$urandom, $urandom})};
      s.m1 = {$urandom, $urandom};
      s.m2 = {29'd0, 35'({$urandom, $urandom}) | 35'd1};
      add_setting(s);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    reset_bodies();

    foreach (dir_rows[i]) begin
      send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].snap);
      if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 30));
    end

    burst_left = 0;
    foreach (plan[ph]) begin
      drain();
      apply_plan(plan[ph]);
      budget = 75;
      while (budget > 0) begin
        if ($urandom_range(0, 6) == 0) begin
          if (burst_left == 0) pause($urandom_range(1, 40));
          send(random_noise());
          budget--;
        end else begin
          for (int k = 0; k < 4; k++) begin
            p[k] = rand_q($urandom_range(0, 1));
            v[k] = rand_q($urandom_range(0, 1));
          end
          t0 = q_t'(t_end_q - dt_q * $urandom_range(0, 30));
          if ($urandom_range(0, 7) == 0) t0 = rand_q(1);
          send(load_of(p, v, t0));
          n_ticks = $urandom_range(1, 14);
          for (int j = 0; j < n_ticks; j++) begin
            if (burst_left == 0) begin
              if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 25));
              burst_left = $urandom_range(1, 12);
            end
            burst_left--;
            send(tick_of($urandom_range(0, 1)));
          end
          budget -= n_ticks + 1;
        end
      end
    end

    drain();
    if (mismatches == 0 && snapshots.size() == 0) begin
      $display("[two_body_gravity_integrator_unit] OK");
    end else begin
      $display("[two_body_gravity_integrator_unit] ERROR");
    end
    $finish;
  end

endmodule
